>>> rtl/float32_multiplier_macros.svh
// assertion macros for the float32 multiplier
// used by rtl/float32_multiplier.sv
`ifndef FLOAT32_MULTIPLIER_MACROS_SVH
`define FLOAT32_MULTIPLIER_MACROS_SVH

// check a property on clk, off during reset
`define FM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property on clk, also during reset
`define FM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/fmul_pkg.sv
// shared types and constants for the float32 multiplier
// no dependencies
`default_nettype none
package fmul_pkg;
  localparam int ExpW = 8;
  localparam int FracW = 23;
  localparam int MantW = FracW + 1;
  localparam int ProdW = 2 * MantW;
  localparam logic [ExpW-1:0] ExpMax = '1;
  localparam logic [FracW-1:0] NanFrac = '1;

  typedef struct packed {
    logic [31:0] product;
    logic overflow_flag;
    logic is_nan;
  } fmul_res_t;
endpackage
`default_nettype wire

>>> rtl/fmul_core.sv
// combinational binary32 multiply, round to nearest even
// depends on fmul_pkg
`default_nettype none
module fmul_core (
  input  wire logic [31:0] operand_a,
  input  wire logic [31:0] operand_b,
  output fmul_pkg::fmul_res_t res
);
  import fmul_pkg::*;

  logic sign;
  logic [ExpW-1:0] ex, ey;
  logic [FracW-1:0] fx, fy;
  logic x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
  logic [MantW-1:0] mx, my;
  logic [ProdW-1:0] prod;
  logic [5:0] lead;
  logic signed [11:0] e, sh;
  logic [ProdW-1:0] q, rest_mask;
  logic half, rest;
  logic [33:0] bits;

  always_comb begin
    sign = operand_a[31] ^ operand_b[31];
    ex = operand_a[30:23];
    ey = operand_b[30:23];
    fx = operand_a[22:0];
    fy = operand_b[22:0];
    x_nan = (ex == ExpMax) && (fx != '0);
    y_nan = (ey == ExpMax) && (fy != '0);
    x_inf = (ex == ExpMax) && (fx == '0);
    y_inf = (ey == ExpMax) && (fy == '0);
    x_zero = (ex == '0) && (fx == '0);
    y_zero = (ey == '0) && (fy == '0);
    mx = {(ex != '0), fx};
    my = {(ey != '0), fy};
    prod = mx * my;
    lead = '0;
    for (int i = 1; i < ProdW; i++) begin
      if (prod[i]) lead = 6'(i);
    end
    e = 12'(signed'({4'd0, (ex == '0) ? 8'd1 : ex}))
        + 12'(signed'({4'd0, (ey == '0) ? 8'd1 : ey}))
        - 12'sd173 + 12'(signed'({6'd0, lead}));
    sh = 12'(signed'({6'd0, lead})) - 12'sd23;
    if (e < 12'sd1) begin
      sh = sh + 12'sd1 - e;
      e = 12'sd1;
    end
    half = 1'b0;
    rest = 1'b0;
    rest_mask = '0;
    if (sh <= 12'sd0) begin
      q = prod << (-sh);
    end else if (sh >= 12'sd49) begin
      q = '0;
    end else begin
      q = prod >> sh;
      half = prod[6'(sh - 12'sd1)];
      rest_mask = (ProdW'(1) << (sh - 12'sd1)) - ProdW'(1);
      rest = (prod & rest_mask) != '0;
      if (half && (rest || q[0])) q = q + ProdW'(1);
    end
    bits = {11'(unsigned'(e - 12'sd1)), 23'd0} + 34'(q);
    res = '0;
    if (x_nan || y_nan || (x_inf && y_zero) || (y_inf && x_zero)) begin
      res.product = {sign, ExpMax, NanFrac};
      res.is_nan = 1'b1;
    end else if (x_inf || y_inf) begin
      res.product = {sign, ExpMax, 23'd0};
    end else if (x_zero || y_zero) begin
      res.product = {sign, 31'd0};
    end else if (bits >= 34'h7F800000) begin
      res.product = {sign, ExpMax, 23'd0};
      res.overflow_flag = 1'b1;
    end else begin
      res.product = {sign, bits[30:0]};
    end
  end
endmodule
`default_nettype wire

>>> rtl/float32_multiplier.sv
// binary32 multiplier top level: input register, multiply, result register
// each item goes from input accept through the input reg, then the result reg, to the result output
// throughput one item per cycle; stalls only while the result register is held
// rst (sync, active high) empties both stages
// depends on fmul_pkg, fmul_core, float32_multiplier_macros.svh
`default_nettype none
`include "float32_multiplier_macros.svh"
module float32_multiplier (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [63:0] s_tdata,  // operand_a, operand_b
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [39:0] m_tdata   // product, overflow_flag, is_nan, zero pad
);
  import fmul_pkg::*;

  logic in_valid, out_valid, in_ready;
  logic [63:0] in_data;
  fmul_res_t res;

  fmul_core u_core (.operand_a(in_data[31:0]), .operand_b(in_data[63:32]), .res(res));

  assign m_tvalid = out_valid;
  assign in_ready = !out_valid || m_tready;
  assign s_tready = !in_valid || in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (in_ready) out_valid <= in_valid;
    end
    if (s_tready && s_tvalid) in_data <= s_tdata;
    if (in_ready && in_valid) m_tdata <= {6'd0, res.is_nan, res.overflow_flag, res.product};
  end

  `FM_ASSERT(a_hold, out_valid && !m_tready |=> out_valid && $stable(m_tdata), "result lost")
  `FM_ASSERT(a_flags, out_valid |-> !(m_tdata[32] && m_tdata[33]), "both flags set")
  `FM_ASSERT_ALWAYS(a_rst, rst |=> !m_tvalid, "valid after reset")
endmodule
`default_nettype wire

>>> test/float32_multiplier_test.sv
// testbench for the float32 multiplier: directed table then random operands
// checks every product against the table values or a built-in binary32 multiply predictor
// depends on fmul_pkg and float32_multiplier
`timescale 1ns / 100ps
`default_nettype none
module float32_multiplier_test;
  import fmul_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;

  float32_multiplier dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic chk;
    logic [31:0] p;
    logic ovf;
    logic nanf;
  } row_t;

  fmul_res_t products_due[$];
  int mismatches = 0;
  bit calm = 1'b0;
  bit sending_done = 1'b0;

  function automatic int lead_pos(logic [47:0] v);
    for (int i = 47; i > 0; i--) if (v[i]) return i;
    return 0;
  endfunction

  function automatic fmul_res_t multiply(logic [31:0] x, logic [31:0] y);
    fmul_res_t r;
    logic s;
    logic [7:0] ex, ey;
    logic [22:0] fx, fy;
    logic xn, yn, xi, yi, xz, yz;
    logic [47:0] prod;
    logic [63:0] q, bits, rest;
    int lead, e, sh;
    s = x[31] ^ y[31];
    ex = x[30:23]; ey = y[30:23]; fx = x[22:0]; fy = y[22:0];
    xn = (ex == ExpMax) && (fx != 0); yn = (ey == ExpMax) && (fy != 0);
    xi = (ex == ExpMax) && (fx == 0); yi = (ey == ExpMax) && (fy == 0);
    xz = (ex == 0) && (fx == 0); yz = (ey == 0) && (fy == 0);
    r = '0;
    if (xn || yn || (xi && yz) || (yi && xz)) begin
      r.product = {s, ExpMax, NanFrac};
      r.is_nan = 1'b1;
      return r;
    end
    if (xi || yi) begin
      r.product = {s, ExpMax, 23'd0};
      return r;
    end
    if (xz || yz) begin
      r.product = {s, 31'd0};
      return r;
    end
    prod = {24'd0, (ex != 0), fx} * {24'd0, (ey != 0), fy};
    if (ex == 0) ex = 8'd1;
    if (ey == 0) ey = 8'd1;
    lead = lead_pos(prod);
    e = int'(ex) + int'(ey) - 127 + lead - 46;
    sh = lead - 23;
    if (e < 1) begin
      sh += 1 - e;
      e = 1;
    end
    if (sh <= 0) q = {16'd0, prod} << (-sh);
    else if (sh >= 60) q = '0;
    else begin
      rest = {16'd0, prod} & ((64'd1 << (sh - 1)) - 1);
      q = {16'd0, prod} >> sh;
      if (((({16'd0, prod} >> (sh - 1)) & 64'd1) != 0) && (rest != 0 || q[0])) q++;
    end
    bits = ({32'd0, 32'(e - 1)} << 23) + q;
    if (bits >= 64'h7F800000) begin
      r.product = {s, ExpMax, 23'd0};
      r.overflow_flag = 1'b1;
    end else r.product = {s, bits[30:0]};
    return r;
  endfunction

  task automatic report(string what, fmul_res_t got, fmul_res_t want);
    $display("mismatch %s: got %h ovf %b nan %b, want %h ovf %b nan %b", what,
             got.product, got.overflow_flag, got.is_nan,
             want.product, want.overflow_flag, want.is_nan);
    mismatches++;
  endtask

  function automatic logic [31:0] rand_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'h00;
      1: v[30:23] = 8'hFF;
      2: v[22:0] = '0;
      3: v[30:23] = $urandom_range(0, 3) ? 8'($urandom_range(1, 30)) : 8'h00;
      4: v[30:23] = 8'($urandom_range(200, 254));
      5: v[30:23] = 8'($urandom_range(100, 150));
      6: v[30:0] = $urandom_range(0, 1) ? 31'h0 : {8'hFF, 23'h0};
      default: ;
    endcase
    return v;
  endfunction

  row_t rows[$];

  initial begin
    rows = '{
      '{32'h3F800000, 32'h3F800000, 1, 32'h3F800000, 0, 0},
      '{32'h00000000, 32'h80000000, 1, 32'h80000000, 0, 0},
      '{32'h7F800000, 32'h00000000, 1, 32'h7FFFFFFF, 0, 1},
      '{32'h80000000, 32'hFF800000, 1, 32'h7FFFFFFF, 0, 1},
      '{32'h7FC00000, 32'h3F800000, 1, 32'h7FFFFFFF, 0, 1},
      '{32'h3F800000, 32'hFF800001, 1, 32'hFFFFFFFF, 0, 1},
      '{32'h7F800000, 32'hBF800000, 1, 32'hFF800000, 0, 0},
      '{32'h7F800000, 32'h7F800000, 1, 32'h7F800000, 0, 0},
      '{32'h7F7FFFFF, 32'h7F7FFFFF, 1, 32'h7F800000, 1, 0},
      '{32'hFF7FFFFF, 32'h40000000, 1, 32'hFF800000, 1, 0},
      '{32'h00000001, 32'h00000001, 1, 32'h00000000, 0, 0},
      '{32'h00000001, 32'h3F800000, 1, 32'h00000001, 0, 0},
      '{32'h3F7FFFFF, 32'h3F7FFFFF, 0, 0, 0, 0},
      '{32'h007FFFFF, 32'h3F800001, 0, 0, 0, 0},
      '{32'h00800000, 32'h3F000000, 0, 0, 0, 0},
      '{32'h00FFFFFF, 32'h3F7FFFFF, 0, 0, 0, 0},
      '{32'h00000003, 32'h3F000000, 0, 0, 0, 0},
      '{32'h7F7FFFFF, 32'h3F800001, 0, 0, 0, 0},
      '{32'h3FFFFFFF, 32'h3FFFFFFF, 0, 0, 0, 0},
      '{32'h00400000, 32'h40800000, 0, 0, 0, 0},
      '{32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 0},
      '{32'h7FFFFFFF, 32'h00000000, 0, 0, 0, 0}
    };
  end

  // sender
  initial begin
    fmul_res_t want;
    logic [31:0] a, b;
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    n = 0;
    while (n < rows.size() + 850) begin
      @(posedge clk);
      if (s_tvalid && s_tready) n++;
      if (n == rows.size() + 300 && !(s_tvalid && s_tready) && products_due.size() != 0) begin
        s_tvalid <= 1'b0;
      end else if (n >= rows.size() + 850) begin
        s_tvalid <= 1'b0;
      end else if (s_tvalid && !s_tready) begin
      end else if (!calm && $urandom_range(0, 99) < 14) begin
        s_tvalid <= 1'b0;
      end else begin
        if (n < rows.size()) begin
          a = rows[n].a; b = rows[n].b;
          want = multiply(a, b);
          if (rows[n].chk) begin
            want.product = rows[n].p;
            want.overflow_flag = rows[n].ovf;
            want.is_nan = rows[n].nanf;
          end
        end else begin
          a = rand_operand(); b = rand_operand();
          want = multiply(a, b);
        end
        s_tdata <= {b, a};
        s_tvalid <= 1'b1;
        products_due.push_back(want);
      end
      if (n == rows.size() + 300) begin
        while (products_due.size() != 0 || s_tvalid) begin
          @(posedge clk);
          if (s_tvalid && s_tready) s_tvalid <= 1'b0;
        end
        n++;
      end
      if (n == rows.size() + 400) calm = 1'b1;
      if (n == rows.size() + 550) calm = 1'b0;
    end
    sending_done = 1'b1;
  end

  // receiver
  initial begin
    int k;
    k = 0;
    forever begin
      @(posedge clk);
      if (k == 200) begin
        m_tready <= 1'b0;
        repeat (60) @(posedge clk);
      end
      k++;
      m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 14);
    end
  end

  // checker
  always @(posedge clk) begin
    fmul_res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[33:0];
      got.product = m_tdata[31:0];
      got.overflow_flag = m_tdata[32];
      got.is_nan = m_tdata[33];
      if (products_due.size() == 0) report("unexpected item", got, got);
      else if (got != products_due[0]) report("product", got, products_due.pop_front());
      else void'(products_due.pop_front());
    end
  end

  initial begin
    wait (sending_done);
    wait (products_due.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && products_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
